>>> rtl/iocirp_pkg.sv
// Package for the indirect register port of the parallel I/O chip.
// Holds field widths, register addresses, access codes and reset values.
// No dependencies; every other file of the block but iocirp_ram imports it.
package iocirp_pkg;

	// Field widths
	localparam int DATA_W   = 8;
	localparam int PTR_W    = 6;
	localparam int CFG_IDX_W = 2;
	localparam int REG_DEPTH = 64;

	// Access kind
	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	// Port select codes
	typedef enum logic [1:0] {
		PORT_A   = 2'd0,
		PORT_B   = 2'd1,
		PORT_C   = 2'd2,
		PORT_CTL = 2'd3
	} port_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_A_PINS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_B_PINS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_C_PINS = 2'd2;

	// Register file addresses
	localparam logic [PTR_W-1:0] REG_MICR  = 6'h00;
	localparam logic [PTR_W-1:0] REG_DDR_C = 6'h06;
	localparam logic [PTR_W-1:0] REG_DDR_A = 6'h23;
	localparam logic [PTR_W-1:0] REG_DDR_B = 6'h2b;

	// Reset bit of the master control register and its reset value
	localparam logic [DATA_W-1:0] MICR_RESET = 8'h01;

	// Reset levels of the input pins
	localparam logic [DATA_W-1:0] PORT_A_PINS_RST = 8'h80;
	localparam logic [DATA_W-1:0] PORT_B_PINS_RST = 8'h00;
	localparam logic [DATA_W-1:0] PORT_C_PINS_RST = 8'h00;

endpackage

>>> rtl/iocirp_if.sv
// Handshake channels of the indirect register port: access request,
// read response and configuration write. Depends on iocirp_pkg.

interface iocirp_req_if;
	import iocirp_pkg::*;
	logic              valid;
	logic              ready;
	logic              command;
	logic [1:0]        port_select;
	logic [DATA_W-1:0] write_data;
	modport source (output valid, output command, output port_select,
		output write_data, input ready);
	modport sink (input valid, input command, input port_select,
		input write_data, output ready);
endinterface

interface iocirp_rsp_if;
	import iocirp_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	modport source (output valid, output read_data, input ready);
	modport sink (input valid, input read_data, output ready);
endinterface

interface iocirp_cfg_if;
	import iocirp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/iocirp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module iocirp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/io_chip_indirect_register_port.sv
// Bus side of a parallel I/O chip: ports A, B, C and an indirect control port.
// A control-port read goes through two registers, the registered read of the
// RAM that holds the 64-entry register file and then the response register;
// the block sits in its read state meanwhile and accepts no word.
// Writes of any kind and data-port reads return their word in the cycle after
// acceptance through the response register, and a new word is accepted while
// that response is being taken. Entries never written read as their reset
// value (register 0 reads 0x01, all others 0x00) through a per-entry valid
// bit, so no clearing pass runs after reset. Depends on iocirp_pkg,
// iocirp_if and iocirp_ram.
module io_chip_indirect_register_port (
	input logic         clk,
	input logic         arst_n,
	iocirp_req_if.sink  req,
	iocirp_rsp_if.source rsp,
	iocirp_cfg_if.sink  cfg
);
	import iocirp_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t            state_q;
	logic              rsp_valid_q;
	logic [DATA_W-1:0] rsp_data_q;
	logic [PTR_W-1:0]  ptr_q;
	logic              expecting_q;
	logic              micr_rst_q;
	logic [DATA_W-1:0] ddr_a_q;
	logic [DATA_W-1:0] ddr_b_q;
	logic [DATA_W-1:0] ddr_c_q;
	logic [DATA_W-1:0] latch_a_q;
	logic [DATA_W-1:0] latch_b_q;
	logic [DATA_W-1:0] latch_c_q;
	logic [DATA_W-1:0] pins_a_q;
	logic [DATA_W-1:0] pins_b_q;
	logic [DATA_W-1:0] pins_c_q;
	logic [REG_DEPTH-1:0] valid_q;

	logic              accept;
	logic              is_ctl;
	logic              is_write;
	logic              mem_we;
	logic [PTR_W-1:0]  mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [DATA_W-1:0] mem_rdata;
	logic [DATA_W-1:0] reg_rdata;
	logic [DATA_W-1:0] port_rdata;
	logic [DATA_W-1:0] sel_pins;
	logic [DATA_W-1:0] sel_ddr;
	logic [DATA_W-1:0] sel_latch;

	// Handshakes
	assign req.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign is_ctl    = (req.port_select == PORT_CTL);
	assign is_write  = (req.command == CMD_WRITE);
	assign cfg.ready = 1'b1;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rsp_data_q;

	// Decode control-port writes into a register file write
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = req.write_data;
		if (accept && is_ctl && is_write) begin
			if (micr_rst_q) begin
				mem_we    = 1'b1;
				mem_waddr = REG_MICR;
				mem_wdata = req.write_data & MICR_RESET;
			end else if (expecting_q) begin
				mem_we = 1'b1;
			end
		end
	end

	// Issue the register file read of a control-port read
	assign mem_re = accept && is_ctl && !is_write;

	iocirp_ram #(
		.WIDTH (DATA_W),
		.DEPTH (REG_DEPTH)
	) u_regfile (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (ptr_q),
		.rdata (mem_rdata)
	);

	// Substitute the reset value for entries never written
	always_comb begin
		if (valid_q[ptr_q]) begin
			reg_rdata = mem_rdata;
		end else if (ptr_q == REG_MICR) begin
			reg_rdata = MICR_RESET;
		end else begin
			reg_rdata = '0;
		end
	end

	// Mix input pins with output latches under the direction register
	always_comb begin
		unique case (req.port_select)
			PORT_A: begin
				sel_pins  = pins_a_q;
				sel_ddr   = ddr_a_q;
				sel_latch = latch_a_q;
			end
			PORT_B: begin
				sel_pins  = pins_b_q;
				sel_ddr   = ddr_b_q;
				sel_latch = latch_b_q;
			end
			PORT_C: begin
				sel_pins  = pins_c_q;
				sel_ddr   = ddr_c_q;
				sel_latch = latch_c_q;
			end
			default: begin
				sel_pins  = '0;
				sel_ddr   = '0;
				sel_latch = '0;
			end
		endcase
		port_rdata = (sel_pins & sel_ddr) | (sel_latch & ~sel_ddr);
	end

	// State, pointer, shadows, latches and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
			ptr_q       <= '0;
			expecting_q <= 1'b0;
			micr_rst_q  <= 1'b1;
			ddr_a_q     <= '0;
			ddr_b_q     <= '0;
			ddr_c_q     <= '0;
			latch_a_q   <= '0;
			latch_b_q   <= '0;
			latch_c_q   <= '0;
			pins_a_q    <= PORT_A_PINS_RST;
			pins_b_q    <= PORT_B_PINS_RST;
			pins_c_q    <= PORT_C_PINS_RST;
			valid_q     <= '0;
		end else begin
			// Drop the response once taken
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			// Configuration writes of the pin levels
			if (cfg.valid) begin
				if (cfg.index == CFG_PORT_A_PINS) begin
					pins_a_q <= cfg.data;
				end else if (cfg.index == CFG_PORT_B_PINS) begin
					pins_b_q <= cfg.data;
				end else if (cfg.index == CFG_PORT_C_PINS) begin
					pins_c_q <= cfg.data;
				end
			end

			// Track which register file entries hold written data
			if (mem_we) begin
				valid_q[mem_waddr] <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_ctl) begin
							if (is_write) begin
								rsp_valid_q <= 1'b1;
								rsp_data_q  <= '0;
								if (micr_rst_q) begin
									micr_rst_q  <= req.write_data[0];
									expecting_q <= 1'b0;
								end else if (expecting_q) begin
									expecting_q <= 1'b0;
									if (ptr_q == REG_MICR) begin
										micr_rst_q <= req.write_data[0];
									end
									if (ptr_q == REG_DDR_A) begin
										ddr_a_q <= req.write_data;
									end
									if (ptr_q == REG_DDR_B) begin
										ddr_b_q <= req.write_data;
									end
									if (ptr_q == REG_DDR_C) begin
										ddr_c_q <= req.write_data;
									end
								end else begin
									ptr_q       <= req.write_data[PTR_W-1:0];
									expecting_q <= 1'b1;
								end
							end else begin
								// Wait in ST_READ for the registered read of the register file
								expecting_q <= 1'b0;
								rsp_valid_q <= 1'b0;
								state_q     <= ST_READ;
							end
						end else begin
							rsp_valid_q <= 1'b1;
							if (is_write) begin
								rsp_data_q <= '0;
								unique case (req.port_select)
									PORT_A:  latch_a_q <= req.write_data;
									PORT_B:  latch_b_q <= req.write_data;
									PORT_C:  latch_c_q <= req.write_data;
									default: latch_c_q <= latch_c_q;
								endcase
							end else begin
								rsp_data_q <= port_rdata;
							end
						end
					end
				end
				ST_READ: begin
					rsp_valid_q <= 1'b1;
					rsp_data_q  <= reg_rdata;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/iocirp_chk.sv
// Port-level checker for io_chip_indirect_register_port, bound to the top level.
// Depends on iocirp_pkg and the channel interfaces of iocirp_if.
module iocirp_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          req_command,
	input logic [1:0]                    req_port_select,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [iocirp_pkg::DATA_W-1:0] rsp_read_data
);
	import iocirp_pkg::*;

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// A pending response holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
		else $error("response dropped or changed while stalled");

	// No word is accepted while a response is stuck
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |-> !(rsp_valid && !rsp_ready))
		else $error("request accepted over a stalled response");

	// Every write answers with zero in the next cycle
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_command == CMD_WRITE) |=> rsp_valid && (rsp_read_data == '0))
		else $error("write did not return zero");

	// Data-port accesses answer in the next cycle
	a_port_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_port_select != PORT_CTL) |=> rsp_valid)
		else $error("data port access did not respond in one cycle");

	// Control reads answer through the read state and block the channel meanwhile
	a_ctl_read: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_port_select == PORT_CTL) && (req_command == CMD_READ)
		|=> !req_ready && !rsp_valid ##1 rsp_valid)
		else $error("control read latency broken");

endmodule

bind io_chip_indirect_register_port iocirp_chk u_iocirp_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_command     (req.command),
	.req_port_select (req.port_select),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_read_data   (rsp.read_data)
);

>>> tb/tb_top.sv
// Self-checking bench for io_chip_indirect_register_port: directed accesses from a
// table, then random phases under new pin levels, all scored against a local model.
// Depends on iocirp_pkg, the iocirp_*_if interfaces and the block itself.
module tb_top;
	import iocirp_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 5;
	localparam int MAX_GAP        = 8;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 135;
	localparam int MAX_REPORTS    = 10;
	localparam int WATCHDOG_LIMIT = 2000;

	// Index past the last pin register; the block must ignore it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		cmd_t              cmd;
		port_t             port;
		logic [DATA_W-1:0] data;
		bit                fixed;
		logic [DATA_W-1:0] want;
	} access_row_t;

	localparam int DIRECTED_ROWS = 27;

	// Directed walk: reset reads, reset-bit bypass, pointer/data phases, direction mixing
	access_row_t directed_rows [DIRECTED_ROWS] = '{
		'{CMD_READ,  PORT_A,   8'h00, 1'b1, 8'h00},
		'{CMD_READ,  PORT_B,   8'hff, 1'b1, 8'h00},
		'{CMD_READ,  PORT_CTL, 8'h00, 1'b1, 8'h01},
		'{CMD_WRITE, PORT_CTL, 8'hfe, 1'b1, 8'h00},
		'{CMD_READ,  PORT_CTL, 8'h00, 1'b1, 8'h00},
		'{CMD_WRITE, PORT_CTL, 8'h23, 1'b1, 8'h00},
		'{CMD_WRITE, PORT_CTL, 8'hff, 1'b1, 8'h00},
		'{CMD_READ,  PORT_A,   8'h00, 1'b1, 8'h80},
		'{CMD_WRITE, PORT_A,   8'h5a, 1'b1, 8'h00},
		'{CMD_WRITE, PORT_CTL, 8'h23, 1'b1, 8'h00},
		'{CMD_WRITE, PORT_CTL, 8'h0f, 1'b1, 8'h00},
		'{CMD_READ,  PORT_A,   8'h00, 1'b0, 8'h00},
		'{CMD_WRITE, PORT_CTL, 8'heb, 1'b1, 8'h00},
		'{CMD_WRITE, PORT_CTL, 8'haa, 1'b1, 8'h00},
		'{CMD_WRITE, PORT_B,   8'hff, 1'b1, 8'h00},
		'{CMD_READ,  PORT_B,   8'h00, 1'b0, 8'h00},
		'{CMD_WRITE, PORT_CTL, 8'h06, 1'b1, 8'h00},
		'{CMD_READ,  PORT_CTL, 8'h00, 1'b1, 8'h00},
		'{CMD_WRITE, PORT_CTL, 8'hc6, 1'b1, 8'h00},
		'{CMD_WRITE, PORT_CTL, 8'hf0, 1'b1, 8'h00},
		'{CMD_WRITE, PORT_C,   8'h3c, 1'b1, 8'h00},
		'{CMD_READ,  PORT_C,   8'h00, 1'b0, 8'h00},
		'{CMD_WRITE, PORT_CTL, 8'h3f, 1'b1, 8'h00},
		'{CMD_WRITE, PORT_CTL, 8'hff, 1'b1, 8'h00},
		'{CMD_READ,  PORT_CTL, 8'h00, 1'b1, 8'hff},
		'{CMD_WRITE, PORT_CTL, 8'h00, 1'b1, 8'h00},
		'{CMD_WRITE, PORT_CTL, 8'h01, 1'b1, 8'h00}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	iocirp_req_if req_ch ();
	iocirp_rsp_if rsp_ch ();
	iocirp_cfg_if cfg_ch ();

	io_chip_indirect_register_port i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #CLK_HALF clk = ~clk;

	// Local copy of the chip state
	logic [DATA_W-1:0] ctl_regs [REG_DEPTH];
	logic [PTR_W-1:0]  ctl_ptr;
	bit                ptr_loaded;
	logic [DATA_W-1:0] out_latch [3];
	logic [DATA_W-1:0] pin_level [3];

	logic [DATA_W-1:0] expected_read_data [$];
	int                fault_count = 0;
	int                quiet_cycles = 0;
	bit                steady = 1'b0;

	// Apply one access to the local state and return the word the bus sees
	function automatic logic [DATA_W-1:0] apply_access(cmd_t cmd, port_t port,
			logic [DATA_W-1:0] data);
		logic [DATA_W-1:0] dir;
		logic [DATA_W-1:0] word;
		word = '0;
		if (port == PORT_CTL) begin
			if (cmd == CMD_WRITE) begin
				if ((ctl_regs[REG_MICR] & MICR_RESET) != '0) begin
					// reset bit set: bypass the pointer, keep bit 0 only
					ctl_regs[REG_MICR] = data & MICR_RESET;
					ptr_loaded = 1'b0;
				end else if (ptr_loaded) begin
					ctl_regs[ctl_ptr] = data;
					ptr_loaded = 1'b0;
				end else begin
					ctl_ptr = data[PTR_W-1:0];
					ptr_loaded = 1'b1;
				end
			end else begin
				ptr_loaded = 1'b0;
				word = ctl_regs[ctl_ptr];
			end
		end else if (cmd == CMD_WRITE) begin
			out_latch[port] = data;
		end else begin
			case (port)
				PORT_A: dir = ctl_regs[REG_DDR_A];
				PORT_B: dir = ctl_regs[REG_DDR_B];
				default: dir = ctl_regs[REG_DDR_C];
			endcase
			word = (pin_level[port] & dir) | (out_latch[port] & ~dir);
		end
		return word;
	endfunction

	// Pointer targets: direction registers, control register, last entry, or any
	function automatic logic [PTR_W-1:0] pick_reg();
		case ($urandom_range(0, 5))
			0: return REG_MICR;
			1: return REG_DDR_A;
			2: return REG_DDR_B;
			3: return REG_DDR_C;
			4: return '1;
			default: return PTR_W'($urandom);
		endcase
	endfunction

	// Offer one word after a random gap (none in steady phases); predict it once it is taken
	task automatic send_access(cmd_t cmd, port_t port, logic [DATA_W-1:0] data,
			bit fixed, logic [DATA_W-1:0] want);
		int gap;
		logic [DATA_W-1:0] word;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.command     <= cmd;
		req_ch.port_select <= port;
		req_ch.write_data  <= data;
		do @(posedge clk); while (!req_ch.ready);
		word = apply_access(cmd, port, data);
		expected_read_data.push_back(fixed ? want : word);
	endtask

	// Hold off the request side until every read word is back, then let it settle
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (expected_read_data.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one pin register while the block is idle
	task automatic write_pins(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_PORT_A_PINS: pin_level[PORT_A] = val;
			CFG_PORT_B_PINS: pin_level[PORT_B] = val;
			CFG_PORT_C_PINS: pin_level[PORT_C] = val;
			default: ;
		endcase
	endtask

	task automatic note_fault(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("%s: expected %02h, got %02h at %0t", what, want, got, $realtime);
	endtask

	// Response side: stall a random number of cycles before each word, none in steady phases
	initial begin
		int stall;
		forever begin
			stall = steady ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Score returned words and watch for a hang
	always @(posedge clk) begin
		logic [DATA_W-1:0] want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_read_data.size() == 0) begin
					note_fault("read word with none pending", '0, rsp_ch.read_data);
				end else begin
					want = expected_read_data.pop_front();
					if (want !== rsp_ch.read_data)
						note_fault("read word mismatch", want, rsp_ch.read_data);
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[io_chip_indirect_register_port] ERROR");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin
		int issued;
		logic [DATA_W-1:0] ptr_byte;
		logic [DATA_W-1:0] pins [3];

		req_ch.valid       <= 1'b0;
		req_ch.command     <= CMD_READ;
		req_ch.port_select <= PORT_A;
		req_ch.write_data  <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= CFG_PORT_A_PINS;
		cfg_ch.data        <= '0;

		// Reset state of the model
		foreach (ctl_regs[i]) ctl_regs[i] = '0;
		ctl_regs[REG_MICR] = MICR_RESET;
		ctl_ptr = '0;
		ptr_loaded = 1'b0;
		foreach (out_latch[i]) out_latch[i] = '0;
		pin_level[PORT_A] = PORT_A_PINS_RST;
		pin_level[PORT_B] = PORT_B_PINS_RST;
		pin_level[PORT_C] = PORT_C_PINS_RST;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_access(directed_rows[i].cmd, directed_rows[i].port, directed_rows[i].data,
				directed_rows[i].fixed, directed_rows[i].want);

		for (int phase = 0; phase < PHASES; phase++) begin
			// Pick pin levels: all low, all high, then random
			foreach (pins[i])
				pins[i] = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hff : DATA_W'($urandom);
			write_pins(CFG_PORT_A_PINS, pins[0]);
			write_pins(CFG_PORT_B_PINS, pins[1]);
			write_pins(CFG_PORT_C_PINS, pins[2]);
			if (phase == 2)
				write_pins(CFG_SPARE, DATA_W'($urandom));
			steady = (phase % 4 == 1);

			issued = 0;
			while (issued < PHASE_ITEMS) begin
				ptr_byte = {2'($urandom), pick_reg()};
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						send_access(cmd_t'($urandom_range(0, 1)), port_t'($urandom_range(0, 2)),
							DATA_W'($urandom), 1'b0, '0);
						issued += 1;
					end
					3, 4, 5: begin
						// pointer then data
						send_access(CMD_WRITE, PORT_CTL, ptr_byte, 1'b0, '0);
						send_access(CMD_WRITE, PORT_CTL, DATA_W'($urandom), 1'b0, '0);
						issued += 2;
					end
					6, 7: begin
						// pointer then read back
						send_access(CMD_WRITE, PORT_CTL, ptr_byte, 1'b0, '0);
						send_access(CMD_READ, PORT_CTL, DATA_W'($urandom), 1'b0, '0);
						issued += 2;
					end
					8: begin
						// lone control access, breaks pairs
						send_access(cmd_t'($urandom_range(0, 1)), PORT_CTL, DATA_W'($urandom),
							1'b0, '0);
						issued += 1;
					end
					default: begin
						if ($urandom_range(0, 9) == 0)
							drain();
						send_access(CMD_READ, port_t'($urandom_range(0, 2)), DATA_W'($urandom),
							1'b0, '0);
						issued += 1;
					end
				endcase
			end
		end

		steady = 1'b0;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0 && expected_read_data.size() == 0)
			$display("[io_chip_indirect_register_port] OK");
		else
			$display("[io_chip_indirect_register_port] ERROR");
		$finish;
	end

endmodule
